/* rtl/core/crc10_pkg.sv */
// shared constants, types and crc division functions for the crc10 packet error code unit
package crc10_pkg;

  localparam int unsigned CRC_W = 10;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CRC_W-1:0] CRC_SEED = 10'd16;
  localparam logic [CRC_W-1:0] CRC_POLY = 10'h08f;
  localparam logic [BYTE_W-1:0] CTR_KEEP = 8'hfc;

  localparam int unsigned BYTE_STEPS = 8;
  localparam int unsigned FINISH_STEPS = 6;

  typedef logic [CRC_W-1:0] crc_t;

  typedef enum logic {
    MODE_TX = 1'b0,
    MODE_RX = 1'b1
  } mode_t;

  // outcome of one request, handed from the datapath to the top level
  typedef struct packed {
    logic has_code;
    crc_t code;
    crc_t rem_nxt;
  } crc_result_t;

  // one bitwise division step
  function automatic crc_t div_step(input crc_t r);
    crc_t s;
    s = {r[CRC_W-2:0], 1'b0};
    if (r[CRC_W-1]) begin
      s = s ^ CRC_POLY;
    end
    return s;
  endfunction

  function automatic crc_t div_byte(input crc_t r);
    crc_t s;
    s = r;
    for (int unsigned k = 0; k < BYTE_STEPS; k++) begin
      s = div_step(s);
    end
    return s;
  endfunction

  function automatic crc_t div_finish(input crc_t r);
    crc_t s;
    s = r;
    for (int unsigned k = 0; k < FINISH_STEPS; k++) begin
      s = div_step(s);
    end
    return s;
  endfunction

endpackage

/* rtl/core/crc10_datapath.sv */
// combinational crc update for one message byte, with the finishing steps on the last byte
module crc10_datapath (
  input  crc10_pkg::crc_t                    rem,
  input  logic [crc10_pkg::BYTE_W-1:0]       data_byte,
  input  logic                               last_byte,
  input  crc10_pkg::mode_t                   mode,
  input  logic [crc10_pkg::BYTE_W-1:0]       counter_byte,
  output crc10_pkg::crc_result_t             result
);

  crc10_pkg::crc_t mixed;
  crc10_pkg::crc_t after_byte;
  crc10_pkg::crc_t ctr_mix;
  crc10_pkg::crc_t code;

  always_comb begin
    mixed = rem ^ {data_byte, 2'b00};
    after_byte = crc10_pkg::div_byte(mixed);
    // receive mode folds the command counter bits in before finishing
    ctr_mix = after_byte;
    if (mode == crc10_pkg::MODE_RX) begin
      ctr_mix = after_byte ^ {(counter_byte & crc10_pkg::CTR_KEEP), 2'b00};
    end
    code = crc10_pkg::div_finish(ctr_mix);
  end

  always_comb begin
    result.has_code = last_byte;
    result.code = code;
    result.rem_nxt = last_byte ? crc10_pkg::CRC_SEED : after_byte;
  end

endmodule

/* rtl/core/crc10_packet_error_code_unit.sv */
// crc10 packet error code unit: input register, crc update and result register
//
// usage:
//   in_* channel: one message byte per request, with in_last_byte marking the
//   final byte; in_mode and in_counter_byte only matter on the final byte
//   (receive mode mixes bits 7..2 of the counter byte before finishing).
//   out_* channel: one 10-bit code per message, emitted for the final byte.
//   result path: a final byte taken into the input register passes through the
//   crc update into the result register; an untaken code can hold it back.
//   throughput: one byte per cycle unless a final byte stalls; the crc update
//   is a single registered pass from the input register to the running remainder.
//   stall: while the result register holds an untaken code, a final byte
//   waits in the input register; non-final bytes keep flowing since they
//   make no result. in_ready drops only when the input register is blocked.
//   reset: both registers empty, running remainder at the seed 16.
module crc10_packet_error_code_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [crc10_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                          in_last_byte,
  input  logic                          in_mode,
  input  logic [crc10_pkg::BYTE_W-1:0]  in_counter_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [crc10_pkg::CRC_W-1:0]   out_pec_code
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic [crc10_pkg::BYTE_W-1:0]  s1_data_r;
  logic                          s1_last_r;
  crc10_pkg::mode_t              s1_mode_r;
  logic [crc10_pkg::BYTE_W-1:0]  s1_ctr_r;
  crc10_pkg::crc_t               rem_r, rem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  crc10_pkg::crc_t               code_r;

  crc10_pkg::crc_result_t        result;
  logic                          s1_adv;
  logic                          in_take;
  logic                          out_free;

  crc10_datapath u_datapath (
    .rem          (rem_r),
    .data_byte    (s1_data_r),
    .last_byte    (s1_last_r),
    .mode         (s1_mode_r),
    .counter_byte (s1_ctr_r),
    .result       (result)
  );

  always_comb begin
    out_free = !out_valid_r || out_ready;
    // a byte with no code never waits on the result side
    s1_adv = s1_valid_r && (!result.has_code || out_free);
    in_ready = !s1_valid_r || s1_adv;
    in_take = in_valid && in_ready;
    s1_valid_nxt = in_take || (s1_valid_r && !s1_adv);
    rem_nxt = s1_adv ? result.rem_nxt : rem_r;
    out_valid_nxt = (s1_adv && result.has_code) || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      rem_r <= crc10_pkg::CRC_SEED;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      rem_r <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
      s1_mode_r <= crc10_pkg::mode_t'(in_mode);
      s1_ctr_r <= in_counter_byte;
    end
    if (s1_adv && result.has_code) begin
      code_r <= result.code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pec_code = code_r;

`ifndef NO_ASSERTIONS
  a_seed_after_code: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> rem_r == crc10_pkg::CRC_SEED)
    else $error("remainder not back at seed after a final byte");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input blocked while input register is empty");

  a_code_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("code appeared without a final byte");

  a_last_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_ready
    |=> s1_valid_r && s1_last_r && $stable(rem_r))
    else $error("final byte lost or remainder moved during output stall");
`endif

endmodule

/* bench/tb_crc10_packet_error_code_unit.sv */
// testbench for the crc10 packet error code unit: directed and random byte streams checked against a predictor
module tb_crc10_packet_error_code_unit;

  localparam int unsigned HOLD_LEN = 300;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_REQS = 1150;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef logic [crc10_pkg::BYTE_W-1:0] pec_byte_t;

  typedef struct {
    pec_byte_t         data_byte;
    logic              last_byte;
    crc10_pkg::mode_t  mode;
    pec_byte_t         counter_byte;
  } pec_req_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  pec_byte_t                   in_data_byte;
  logic                        in_last_byte;
  logic                        in_mode;
  pec_byte_t                   in_counter_byte;
  logic                        out_valid;
  logic                        out_ready;
  logic [crc10_pkg::CRC_W-1:0] out_pec_code;

  pec_req_t        pending_reqs[$];
  crc10_pkg::crc_t pec_expected[$];
  crc10_pkg::crc_t running_rem;
  bit              in_taken;
  bit              out_taken;
  int unsigned     req_count;
  int unsigned     mismatch_count;
  int unsigned     send_gap;
  int unsigned     rx_gap;
  int unsigned     hold_left;
  logic [1:0]      hold_idx;
  int unsigned     idle_cycles;
  int unsigned     hold_at[2] = '{300, 800};

  crc10_packet_error_code_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .in_mode         (in_mode),
    .in_counter_byte (in_counter_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pec_code    (out_pec_code)
  );

  always #5 clk = ~clk;

  // shift the remainder n times, folding in the polynomial when the top bit falls out
  function automatic crc10_pkg::crc_t crc_shift(input crc10_pkg::crc_t r, input int unsigned n);
    crc10_pkg::crc_t s;
    logic top;
    s = r;
    for (int unsigned k = 0; k < n; k++) begin
      top = s[crc10_pkg::CRC_W-1];
      s = crc10_pkg::crc_t'(s << 1);
      if (top) begin
        s = s ^ crc10_pkg::CRC_POLY;
      end
    end
    return s;
  endfunction

  // idle length: mostly none or short, a few long; calm stretches have none
  function automatic int unsigned pick_gap();
    int unsigned r;
    if ((req_count / 150) % 3 == 1) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(input pec_byte_t data, input logic last, input crc10_pkg::mode_t mode,
                         input pec_byte_t ctr);
    pec_req_t req;
    req.data_byte = data;
    req.last_byte = last;
    req.mode = mode;
    req.counter_byte = ctr;
    pending_reqs.push_back(req);
  endtask

  // predictor and result checker
  always @(posedge clk) begin
    crc10_pkg::crc_t nxt;
    crc10_pkg::crc_t got;
    crc10_pkg::crc_t want;
    in_taken = rst_n && in_valid && in_ready;
    out_taken = rst_n && out_valid && out_ready;
    if (!rst_n) begin
      running_rem = crc10_pkg::CRC_SEED;
    end else begin
      if (in_taken) begin
        req_count++;
        nxt = crc_shift(running_rem ^ {in_data_byte, 2'b00}, crc10_pkg::BYTE_STEPS);
        if (in_last_byte) begin
          if (crc10_pkg::mode_t'(in_mode) == crc10_pkg::MODE_RX) begin
            nxt = nxt ^ {in_counter_byte & crc10_pkg::CTR_KEEP, 2'b00};
          end
          pec_expected.push_back(crc_shift(nxt, crc10_pkg::FINISH_STEPS));
          running_rem = crc10_pkg::CRC_SEED;
        end else begin
          running_rem = nxt;
        end
      end
      if (out_taken) begin
        got = out_pec_code;
        if (pec_expected.size() == 0) begin
          $display("%0t: unexpected pec_code, expected none, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = pec_expected.pop_front();
          if (got !== want) begin
            $display("%0t: pec_code mismatch, expected %h, got %h", $time, want, got);
            mismatch_count++;
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    pec_req_t req;
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_valid) begin
        send_gap = pick_gap();
      end
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= req.data_byte;
        in_last_byte <= req.last_byte;
        in_mode <= req.mode;
        in_counter_byte <= req.counter_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with long hold-offs to back the block up
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_idx < 2'd2 && req_count >= hold_at[hold_idx[0]]) begin
        out_ready <= 1'b0;
        hold_left = HOLD_LEN - 1;
        hold_idx++;
      end else begin
        if (rx_gap == 0 && (out_taken || $urandom_range(0, 15) == 0)) begin
          rx_gap = pick_gap();
        end
        if (rx_gap != 0) begin
          out_ready <= 1'b0;
          rx_gap--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no request and no result taken
  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("** crc10_packet_error_code_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned len;
    int unsigned r;
    pec_byte_t data;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    in_mode = 1'b0;
    in_counter_byte = '0;
    out_ready = 1'b0;
    running_rem = crc10_pkg::CRC_SEED;
    req_count = 0;
    mismatch_count = 0;
    send_gap = 0;
    rx_gap = 0;
    hold_left = 0;
    hold_idx = '0;
    idle_cycles = 0;

    // single-byte messages at the extremes, both modes
    add_req(8'h00, 1'b1, crc10_pkg::MODE_TX, 8'h00);
    add_req(8'hff, 1'b1, crc10_pkg::MODE_TX, 8'hff);
    add_req(8'h00, 1'b1, crc10_pkg::MODE_RX, 8'h00);
    add_req(8'hff, 1'b1, crc10_pkg::MODE_RX, 8'hff);
    // counter low bits must not matter
    add_req(8'h5a, 1'b1, crc10_pkg::MODE_RX, 8'h03);
    add_req(8'h5a, 1'b1, crc10_pkg::MODE_RX, 8'h00);
    add_req(8'ha5, 1'b1, crc10_pkg::MODE_RX, 8'hfc);
    // mode and counter on non-final bytes are don't-care
    add_req(8'h12, 1'b0, crc10_pkg::MODE_RX, 8'hff);
    add_req(8'h34, 1'b0, crc10_pkg::MODE_RX, 8'haa);
    add_req(8'h56, 1'b1, crc10_pkg::MODE_TX, 8'h77);
    add_req(8'hff, 1'b0, crc10_pkg::MODE_TX, 8'h00);
    add_req(8'hff, 1'b0, crc10_pkg::MODE_RX, 8'h55);
    add_req(8'hff, 1'b1, crc10_pkg::MODE_RX, 8'h80);
    // seed must be back after a code
    add_req(8'h00, 1'b1, crc10_pkg::MODE_TX, 8'h00);
    add_req(8'h01, 1'b0, crc10_pkg::MODE_TX, 8'hff);
    add_req(8'h80, 1'b0, crc10_pkg::MODE_RX, 8'h01);
    add_req(8'h7f, 1'b1, crc10_pkg::MODE_RX, 8'h04);
    add_req(8'h00, 1'b0, crc10_pkg::MODE_TX, 8'h00);
    add_req(8'h00, 1'b1, crc10_pkg::MODE_TX, 8'hff);

    // random messages, mostly short
    n = 0;
    while (n < RANDOM_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        len = $urandom_range(1, 6);
      end else if (r < 97) begin
        len = $urandom_range(7, 20);
      end else begin
        len = $urandom_range(21, 48);
      end
      for (int unsigned k = 0; k < len; k++) begin
        r = $urandom_range(0, 9);
        data = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : pec_byte_t'($urandom);
        add_req(data, k == len - 1, crc10_pkg::mode_t'($urandom_range(0, 1)),
                pec_byte_t'($urandom));
      end
      n += len;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || pec_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pec_expected.size() != 0) begin
      $display("%0t: %0d expected pec_code values never arrived", $time, pec_expected.size());
    end
    if (mismatch_count == 0 && pec_expected.size() == 0) begin
      $display("** crc10_packet_error_code_unit: PASSED **");
    end else begin
      $display("** crc10_packet_error_code_unit: FAILED **");
    end
    $finish;
  end

endmodule
